@@ hdl/plate_permit_access_table_assert.svh @@
// Assertion macros shared by the plate permit/access table RTL.
`ifndef PLATE_PERMIT_ACCESS_TABLE_ASSERT_SVH
`define PLATE_PERMIT_ACCESS_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PPAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PPAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ppat_pkg.sv @@
// Shared types and constants for the plate permit/access table.
package ppat_pkg;

    localparam int PLATE_W      = 56;
    localparam int ENTRY_W      = 7;
    localparam int STATUS_W     = 3;
    localparam int OPCODE_W     = 2;
    localparam int ACCESS_DEPTH = 64;
    localparam int PERMIT_DEPTH = 64;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD_PERMIT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD_ACCESS = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CHECK      = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_IN_ACCESS    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_AUTH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCESS_ADDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PERMIT_ADDED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PERMIT_DUP   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd5;

    // Command to a table engine
    typedef struct packed {
        logic start;
        logic insert;
    } tbl_cmd_t;

    // Result of one table pass (valid while done is high)
    typedef struct packed {
        logic done;
        logic hit;
        logic stored;
    } tbl_res_t;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_SCAN,
        TBL_SHIFT
    } tbl_state_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_DISPATCH,
        CTL_PERMIT,
        CTL_ACCESS,
        CTL_CHK_ACC,
        CTL_CHK_PERM,
        CTL_RESP
    } ctl_state_t;

endpackage

@@ hdl/plate_permit_access_table.sv @@
// Plate permit/access table top level: item sequencer and result register.
//
// Input channel s_valid/s_ready carries one transaction per item: s_opcode and
// s_plate. Result channel m_valid/m_ready returns exactly one transaction per
// item: m_status, m_access_entries, m_permit_entries (counts after the item).
// Each table is a sorted RAM walked one entry per cycle by its own engine; a
// pass searches or inserts (an insert ripples the tail up in the same pass).
// Add permit and add access take one pass; the next item is accepted once the
// sequencer has moved the result into the result register and is idle again.
// A check takes up to three passes (access search, permit search, access
// insert); an unused opcode takes no table pass.
// One item is in work at a time; s_ready is high while the sequencer is idle.
// The result register parts the channels: the next item is accepted while a
// result still waits, and a finished item waits only if that register is full
// and m_ready is low.
// Reset (aresetn low, synchronous) empties both tables by clearing their
// counts; no RAM clearing pass is needed, so items are accepted right after.
module plate_permit_access_table #(
    parameter int ACCESS_DEPTH = ppat_pkg::ACCESS_DEPTH,
    parameter int PERMIT_DEPTH = ppat_pkg::PERMIT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ppat_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [ppat_pkg::PLATE_W-1:0]   s_plate,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ppat_pkg::STATUS_W-1:0]  m_status,
    output logic [ppat_pkg::ENTRY_W-1:0]   m_access_entries,
    output logic [ppat_pkg::ENTRY_W-1:0]   m_permit_entries
);

    `include "plate_permit_access_table_assert.svh"

    localparam int ACW = $clog2(ACCESS_DEPTH + 1);
    localparam int PCW = $clog2(PERMIT_DEPTH + 1);

    ppat_pkg::ctl_state_t state_reg, state_next;
    logic [ppat_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [ppat_pkg::PLATE_W-1:0]  plate_reg, plate_next;
    logic [ppat_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ppat_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ppat_pkg::ENTRY_W-1:0]  m_acc_reg, m_acc_next;
    logic [ppat_pkg::ENTRY_W-1:0]  m_perm_reg, m_perm_next;

    ppat_pkg::tbl_cmd_t acc_cmd, perm_cmd;
    ppat_pkg::tbl_res_t acc_res, perm_res;
    logic [ACW-1:0]     acc_count;
    logic [PCW-1:0]     perm_count;

    ppat_table #(
        .DEPTH (ACCESS_DEPTH)
    ) u_access (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (acc_cmd),
        .key     (plate_reg),
        .res     (acc_res),
        .count   (acc_count)
    );

    ppat_table #(
        .DEPTH (PERMIT_DEPTH)
    ) u_permit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (perm_cmd),
        .key     (plate_reg),
        .res     (perm_res),
        .count   (perm_count)
    );

    assign s_ready          = (state_reg == ppat_pkg::CTL_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_access_entries = m_acc_reg;
    assign m_permit_entries = m_perm_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ppat_pkg::CTL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        plate_reg    <= plate_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_acc_reg    <= m_acc_next;
        m_perm_reg   <= m_perm_next;
    end

    // Sequencer: dispatch passes to the tables and build the status
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        plate_next    = plate_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_acc_next    = m_acc_reg;
        m_perm_next   = m_perm_reg;
        acc_cmd       = '0;
        perm_cmd      = '0;

        unique case (state_reg)
            ppat_pkg::CTL_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    plate_next = s_plate;
                    state_next = ppat_pkg::CTL_DISPATCH;
                end
            end

            ppat_pkg::CTL_DISPATCH: begin
                unique case (op_reg)
                    ppat_pkg::OP_ADD_PERMIT: begin
                        perm_cmd   = '{start: 1'b1, insert: 1'b1};
                        state_next = ppat_pkg::CTL_PERMIT;
                    end
                    ppat_pkg::OP_ADD_ACCESS: begin
                        acc_cmd    = '{start: 1'b1, insert: 1'b1};
                        state_next = ppat_pkg::CTL_ACCESS;
                    end
                    ppat_pkg::OP_CHECK: begin
                        acc_cmd    = '{start: 1'b1, insert: 1'b0};
                        state_next = ppat_pkg::CTL_CHK_ACC;
                    end
                    default: begin
                        status_next = ppat_pkg::ST_NOT_AUTH;
                        state_next  = ppat_pkg::CTL_RESP;
                    end
                endcase
            end

            ppat_pkg::CTL_PERMIT: begin
                if (perm_res.done) begin
                    status_next = perm_res.hit    ? ppat_pkg::ST_PERMIT_DUP :
                                  perm_res.stored ? ppat_pkg::ST_PERMIT_ADDED :
                                                    ppat_pkg::ST_FULL;
                    state_next  = ppat_pkg::CTL_RESP;
                end
            end

            ppat_pkg::CTL_ACCESS: begin
                if (acc_res.done) begin
                    status_next = acc_res.hit    ? ppat_pkg::ST_IN_ACCESS :
                                  acc_res.stored ? ppat_pkg::ST_ACCESS_ADDED :
                                                   ppat_pkg::ST_FULL;
                    state_next  = ppat_pkg::CTL_RESP;
                end
            end

            ppat_pkg::CTL_CHK_ACC: begin
                if (acc_res.done) begin
                    if (acc_res.hit) begin
                        status_next = ppat_pkg::ST_IN_ACCESS;
                        state_next  = ppat_pkg::CTL_RESP;
                    end else begin
                        perm_cmd   = '{start: 1'b1, insert: 1'b0};
                        state_next = ppat_pkg::CTL_CHK_PERM;
                    end
                end
            end

            ppat_pkg::CTL_CHK_PERM: begin
                if (perm_res.done) begin
                    if (!perm_res.hit) begin
                        status_next = ppat_pkg::ST_NOT_AUTH;
                        state_next  = ppat_pkg::CTL_RESP;
                    end else begin
                        // permitted: insert into access, reported as a direct add
                        acc_cmd    = '{start: 1'b1, insert: 1'b1};
                        state_next = ppat_pkg::CTL_ACCESS;
                    end
                end
            end

            ppat_pkg::CTL_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_acc_next    = ppat_pkg::ENTRY_W'(acc_count);
                    m_perm_next   = ppat_pkg::ENTRY_W'(perm_count);
                    state_next    = ppat_pkg::CTL_IDLE;
                end
            end

            default: begin
                state_next = ppat_pkg::CTL_IDLE;
            end
        endcase
    end

    // Checks on the table engines and the sequencer
    `PPAT_ASSERT_NOW(a_acc_bound, 1'b1, acc_count <= ACW'(ACCESS_DEPTH), "access count over depth")
    `PPAT_ASSERT_NOW(a_perm_bound, 1'b1, perm_count <= PCW'(PERMIT_DEPTH), "permit count over depth")
    `PPAT_ASSERT_NEXT(a_acc_grow, acc_res.stored, acc_count == $past(acc_count) + 1'b1, "access count not bumped")
    `PPAT_ASSERT_NOW(a_one_pass, 1'b1, !(acc_res.done && perm_res.done), "two table passes at once")

endmodule

@@ hdl/ppat_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ppat_ram #(
    parameter int WIDTH = ppat_pkg::PLATE_W,
    parameter int DEPTH = ppat_pkg::ACCESS_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ppat_table.sv @@
// One sorted plate table: RAM, entry count and a scan/insert engine.
module ppat_table #(
    parameter int DEPTH = ppat_pkg::ACCESS_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ppat_pkg::tbl_cmd_t           cmd,
    input  logic [ppat_pkg::PLATE_W-1:0] key,
    output ppat_pkg::tbl_res_t           res,
    output logic [CW-1:0]                count
);

    ppat_pkg::tbl_state_t state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                idx_inc;
    logic [ppat_pkg::PLATE_W-1:0] hold_reg, hold_next;
    logic                         insert_reg, insert_next;
    logic                         full;

    logic                         we;
    logic [AW-1:0]                wr_addr;
    logic [ppat_pkg::PLATE_W-1:0] wr_data;
    logic [AW-1:0]                rd_addr;
    logic [ppat_pkg::PLATE_W-1:0] rd_data;

    ppat_ram #(
        .WIDTH (ppat_pkg::PLATE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_inc = idx_reg + 1'b1;
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppat_pkg::TBL_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Scan pointer and carried entry
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        hold_reg   <= hold_next;
        insert_reg <= insert_next;
    end

    // One entry per cycle: read ahead at idx+1 while comparing entry idx.
    // An insert writes the key at its slot, then ripples the tail up one place.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        insert_next = insert_reg;
        we          = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = hold_reg;
        rd_addr     = idx_inc[AW-1:0];
        res         = '0;

        unique case (state_reg)
            ppat_pkg::TBL_IDLE: begin
                rd_addr = '0;
                if (cmd.start) begin
                    idx_next    = '0;
                    insert_next = cmd.insert;
                    state_next  = ppat_pkg::TBL_SCAN;
                end
            end

            ppat_pkg::TBL_SCAN: begin
                if (idx_reg == count_reg) begin
                    // end of table, key is larger than all entries
                    res.done   = 1'b1;
                    state_next = ppat_pkg::TBL_IDLE;
                    if (insert_reg && !full) begin
                        we         = 1'b1;
                        wr_data    = key;
                        count_next = count_reg + 1'b1;
                        res.stored = 1'b1;
                    end
                end else if (rd_data < key) begin
                    idx_next = idx_inc;
                end else if (rd_data == key) begin
                    res.done   = 1'b1;
                    res.hit    = 1'b1;
                    state_next = ppat_pkg::TBL_IDLE;
                end else if (insert_reg && !full) begin
                    we         = 1'b1;
                    wr_data    = key;
                    hold_next  = rd_data;
                    idx_next   = idx_inc;
                    state_next = ppat_pkg::TBL_SHIFT;
                end else begin
                    res.done   = 1'b1;
                    state_next = ppat_pkg::TBL_IDLE;
                end
            end

            ppat_pkg::TBL_SHIFT: begin
                we = 1'b1;
                if (idx_reg == count_reg) begin
                    // last carried entry lands in the new top slot
                    count_next = count_reg + 1'b1;
                    res.done   = 1'b1;
                    res.stored = 1'b1;
                    state_next = ppat_pkg::TBL_IDLE;
                end else begin
                    hold_next = rd_data;
                    idx_next  = idx_inc;
                end
            end

            default: begin
                state_next = ppat_pkg::TBL_IDLE;
            end
        endcase
    end

endmodule
